// ===== rtl/sixax_pkg.sv =====
package sixax_pkg;

   localparam int AXES = 6;
   localparam int SLOT_BITS = 3;
   localparam int COUNT_BITS = 4;
   localparam int GAIN_BITS = 20;
   localparam int COORD_BITS = 22;
   localparam int BUTTON_BITS = 2;
   localparam int TYPE_BITS = 5;
   localparam int CODE_BITS = 10;
   localparam int EVENT_BITS = 16;
   localparam int FRAC_SHIFT = 16;
   localparam int LIMIT_BITS = 21;

   localparam logic [COUNT_BITS-1:0] IDLE_MAX = 4'd15;
   localparam logic [LIMIT_BITS-1:0] COORD_LIMIT = 21'd1100000;
   localparam logic [SLOT_BITS-1:0] RUN_LAST = 3'd7;

   localparam logic [TYPE_BITS-1:0] EV_KEY = 5'd1;
   localparam logic [TYPE_BITS-1:0] EV_REL = 5'd2;
   localparam logic [TYPE_BITS-1:0] EV_ABS = 5'd3;
   localparam logic [CODE_BITS-1:0] BTN_CODE_ONE = 10'd256;
   localparam logic [CODE_BITS-1:0] BTN_CODE_TWO = 10'd257;

   localparam logic [COUNT_BITS-1:0] IDLE_THRESHOLD_RESET = 4'd3;
   localparam logic [GAIN_BITS-1:0] TRANS_GAIN_RESET = 20'd16777;
   localparam logic [GAIN_BITS-1:0] ROT_GAIN_RESET = 20'd13422;

   typedef enum logic [1:0] {
      CSR_IDLE_THRESHOLD = 2'd0,
      CSR_TRANS_GAIN     = 2'd1,
      CSR_ROT_GAIN       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 ev_write;
      logic                 frame_update;
      logic                 issue;
      logic [SLOT_BITS-1:0] slot;
      logic                 load;
   } cmd_type;

   typedef struct packed {
      logic frame_has_event;
   } status_type;

   function automatic logic [SLOT_BITS-1:0] slot_axis(input logic [SLOT_BITS-1:0] slot);
      logic [SLOT_BITS-1:0] axis;
      case (slot)
         3'd0: axis = 3'd0;
         3'd1: axis = 3'd2;
         3'd2: axis = 3'd1;
         3'd3: axis = 3'd3;
         3'd4: axis = 3'd5;
         3'd5: axis = 3'd4;
         default: axis = 3'd0;
      endcase
      return axis;
   endfunction

   function automatic logic slot_negated(input logic [SLOT_BITS-1:0] slot);
      logic neg;
      case (slot)
         3'd1, 3'd2, 3'd4, 3'd5: neg = 1'b1;
         default: neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage

// ===== rtl/sixax_ctrl.sv =====
module sixax_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sixax_pkg::status_type status,
   output sixax_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_LOAD
   } state_type;

   state_type                       state_ff, state_in;
   logic [sixax_pkg::SLOT_BITS-1:0] cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.ev_write     = accept && !req_action;
      cmd.frame_update = accept && req_action && status.frame_has_event;
      cmd.issue        = (state_ff == ST_RUN) &&
                         (cnt_ff < sixax_pkg::SLOT_BITS'(sixax_pkg::AXES));
      cmd.slot         = cnt_ff;
      cmd.load         = (state_ff == ST_LOAD) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.frame_update) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sixax_pkg::RUN_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cmd.load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/sixax_dpath.sv =====
module sixax_dpath #(
   parameter int VALUE_BITS = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [sixax_pkg::TYPE_BITS-1:0]          req_event_type,
   input  logic [sixax_pkg::CODE_BITS-1:0]          req_event_code,
   input  logic signed [sixax_pkg::EVENT_BITS-1:0]  req_event_value,
   input  logic [sixax_pkg::COUNT_BITS-1:0]         idle_threshold,
   input  logic [sixax_pkg::GAIN_BITS-1:0]          trans_gain,
   input  logic [sixax_pkg::GAIN_BITS-1:0]          rot_gain,
   input  sixax_pkg::cmd_type                       cmd,
   output sixax_pkg::status_type                    status,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_tx,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_tz_neg,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_ty_neg,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_rx,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_rz_neg,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_ry_neg,
   output logic [sixax_pkg::BUTTON_BITS-1:0]        rsp_button_one,
   output logic [sixax_pkg::BUTTON_BITS-1:0]        rsp_button_two
);

   localparam int ValHi = (1 << (VALUE_BITS - 1)) - 1;
   localparam int ValLo = -ValHi - 1;
   localparam int SqBits = 2 * VALUE_BITS;
   localparam int ProdBits = SqBits + sixax_pkg::GAIN_BITS;
   localparam int RoundBits = ProdBits + 1;
   localparam int QBits = RoundBits - sixax_pkg::FRAC_SHIFT;

   localparam int NA = sixax_pkg::AXES;
   localparam int CB = sixax_pkg::COORD_BITS;
   localparam int SB = sixax_pkg::SLOT_BITS;

   logic signed [VALUE_BITS-1:0]          axis_ff [NA];
   logic signed [VALUE_BITS-1:0]          axis_in [NA];
   logic [sixax_pkg::COUNT_BITS-1:0]      count_ff [NA];
   logic [sixax_pkg::COUNT_BITS-1:0]      count_in [NA];
   logic [NA-1:0]                         active_ff, active_in;
   logic [sixax_pkg::BUTTON_BITS-1:0]     button_ff [2];
   logic [sixax_pkg::BUTTON_BITS-1:0]     button_in [2];
   logic                                  has_event_ff, has_event_in;

   logic signed [sixax_pkg::EVENT_BITS-1:0] clamped;
   logic [sixax_pkg::BUTTON_BITS-1:0]       button_val;
   logic                                    axis_event;

   logic                          s1_valid_ff, s2_valid_ff;
   logic [SB-1:0]                 s1_slot_ff, s2_slot_ff;
   logic                          s1_neg_ff, s2_neg_ff;
   logic                          s1_trans_ff;
   logic [SqBits-1:0]             sq_ff;
   logic [ProdBits-1:0]           prod_ff;
   logic signed [CB-1:0]          slot_ff [NA];

   logic signed [VALUE_BITS-1:0]  sel_val;
   logic                          sel_negf;
   logic                          sign_in;
   logic [VALUE_BITS-1:0]         mag_in;
   logic [sixax_pkg::GAIN_BITS-1:0] gain_sel;
   logic [RoundBits-1:0]          rounded;
   logic [QBits-1:0]              quot;
   logic [sixax_pkg::LIMIT_BITS-1:0] mag_out;
   logic signed [CB-1:0]          shaped;

   assign status.frame_has_event = has_event_ff;

   always_comb begin
      if (req_event_value > sixax_pkg::EVENT_BITS'(ValHi)) begin
         clamped = sixax_pkg::EVENT_BITS'(ValHi);
      end else if (req_event_value < sixax_pkg::EVENT_BITS'(ValLo)) begin
         clamped = sixax_pkg::EVENT_BITS'(ValLo);
      end else begin
         clamped = req_event_value;
      end
      if (req_event_value < 0) begin
         button_val = '0;
      end else if (req_event_value > 16'sd3) begin
         button_val = 2'd3;
      end else begin
         button_val = req_event_value[1:0];
      end
      axis_event = ((req_event_type == sixax_pkg::EV_REL) ||
                    (req_event_type == sixax_pkg::EV_ABS)) &&
                   (req_event_code < sixax_pkg::CODE_BITS'(NA));
   end

   always_comb begin
      logic [sixax_pkg::COUNT_BITS-1:0] next_cnt;
      axis_in      = axis_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      button_in    = button_ff;
      has_event_in = has_event_ff;
      next_cnt     = '0;
      if (cmd.ev_write) begin
         has_event_in = 1'b1;
         if (req_event_type == sixax_pkg::EV_KEY) begin
            if (req_event_code == sixax_pkg::BTN_CODE_ONE) begin
               button_in[0] = button_val;
            end else if (req_event_code == sixax_pkg::BTN_CODE_TWO) begin
               button_in[1] = button_val;
            end
         end else if (axis_event) begin
            axis_in[req_event_code[SB-1:0]]   = clamped[VALUE_BITS-1:0];
            active_in[req_event_code[SB-1:0]] = 1'b1;
         end
      end
      if (cmd.frame_update) begin
         has_event_in = 1'b0;
         active_in    = '0;
         for (int i = 0; i < NA; i++) begin
            if (active_ff[i]) begin
               next_cnt = '0;
            end else if (count_ff[i] == sixax_pkg::IDLE_MAX) begin
               next_cnt = count_ff[i];
            end else begin
               next_cnt = count_ff[i] + 1'b1;
            end
            count_in[i] = next_cnt;
            if (next_cnt >= idle_threshold) begin
               axis_in[i] = '0;
            end
         end
      end
   end

   always_comb begin
      sel_val  = axis_ff[sixax_pkg::slot_axis(cmd.slot)];
      sel_negf = sixax_pkg::slot_negated(cmd.slot);
      sign_in  = sel_negf ? (sel_val > 0) : (sel_val < 0);
      mag_in   = (sel_val < 0) ? VALUE_BITS'(-sel_val) : VALUE_BITS'(sel_val);
      gain_sel = s1_trans_ff ? trans_gain : rot_gain;
      rounded  = RoundBits'(prod_ff) +
                 (s2_neg_ff ? RoundBits'({sixax_pkg::FRAC_SHIFT{1'b1}}) : RoundBits'(0));
      quot     = rounded[RoundBits-1:sixax_pkg::FRAC_SHIFT];
      mag_out  = (quot > QBits'(sixax_pkg::COORD_LIMIT)) ?
                 sixax_pkg::COORD_LIMIT : quot[sixax_pkg::LIMIT_BITS-1:0];
      shaped   = s2_neg_ff ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NA; i++) begin
            axis_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         active_ff    <= '0;
         button_ff[0] <= '0;
         button_ff[1] <= '0;
         has_event_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         axis_ff      <= axis_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         button_ff    <= button_in;
         has_event_ff <= has_event_in;
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_slot_ff  <= cmd.slot;
      s1_neg_ff   <= sign_in;
      s1_trans_ff <= (cmd.slot < SB'(3));
      sq_ff       <= SqBits'(mag_in * mag_in);
      s2_slot_ff  <= s1_slot_ff;
      s2_neg_ff   <= s1_neg_ff;
      prod_ff     <= ProdBits'(sq_ff * gain_sel);
      if (s2_valid_ff) begin
         slot_ff[s2_slot_ff] <= shaped;
      end
      if (cmd.load) begin
         rsp_coord_tx     <= slot_ff[0];
         rsp_coord_tz_neg <= slot_ff[1];
         rsp_coord_ty_neg <= slot_ff[2];
         rsp_coord_rx     <= slot_ff[3];
         rsp_coord_rz_neg <= slot_ff[4];
         rsp_coord_ry_neg <= slot_ff[5];
         rsp_button_one   <= button_ff[0];
         rsp_button_two   <= button_ff[1];
      end
   end

endmodule

// ===== rtl/six_axis_idle_hold_shaper_unit.sv =====
// Six-axis event shaper. Input beats on req_* carry either one input event
// (req_action low) or an end-of-frame mark (req_action high). Events update
// the stored axis and button values when taken, back to back while idle.
// An end-of-frame mark after at least one event updates the idle counters,
// zeroes long-idle axes and runs the six axes through one shared
// square-and-gain pipeline (one axis issued per cycle, two multiply stages),
// then loads one rsp_* beat into the output register; req_stall is high from
// the mark until the load. A frame mark with no event is taken and gives no beat.
// The result sits in an output register: while rsp_stall holds it, events
// and a further frame mark are still taken, and the next frame result waits
// in the shaper (req_stall high) until the held beat leaves.
// The config port (psel/penable/pwrite/paddr/pwdata) writes idle_threshold,
// trans_gain and rot_gain at byte addresses 0, 4 and 8; write only while idle.
// Reset (synchronous, active high) clears axis values, idle counters,
// buttons and the pending result, and restores the default register values.
module six_axis_idle_hold_shaper_unit #(
   parameter int VALUE_BITS = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_action,
   input  logic [sixax_pkg::TYPE_BITS-1:0]          req_event_type,
   input  logic [sixax_pkg::CODE_BITS-1:0]          req_event_code,
   input  logic signed [sixax_pkg::EVENT_BITS-1:0]  req_event_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_tx,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_tz_neg,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_ty_neg,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_rx,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_rz_neg,
   output logic signed [sixax_pkg::COORD_BITS-1:0]  rsp_coord_ry_neg,
   output logic [sixax_pkg::BUTTON_BITS-1:0]        rsp_button_one,
   output logic [sixax_pkg::BUTTON_BITS-1:0]        rsp_button_two,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [3:0]                               paddr,
   input  logic [31:0]                              pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);

   logic [sixax_pkg::COUNT_BITS-1:0] thresh_ff;
   logic [sixax_pkg::GAIN_BITS-1:0]  trans_gain_ff;
   logic [sixax_pkg::GAIN_BITS-1:0]  rot_gain_ff;
   logic                             csr_write;
   sixax_pkg::csr_index_type         csr_index;
   sixax_pkg::cmd_type               cmd;
   sixax_pkg::status_type            status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = sixax_pkg::csr_index_type'(paddr[3:2]);

   always_comb begin
      case (csr_index)
         sixax_pkg::CSR_IDLE_THRESHOLD: prdata = 32'(thresh_ff);
         sixax_pkg::CSR_TRANS_GAIN:     prdata = 32'(trans_gain_ff);
         sixax_pkg::CSR_ROT_GAIN:       prdata = 32'(rot_gain_ff);
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= sixax_pkg::IDLE_THRESHOLD_RESET;
         trans_gain_ff <= sixax_pkg::TRANS_GAIN_RESET;
         rot_gain_ff   <= sixax_pkg::ROT_GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sixax_pkg::CSR_IDLE_THRESHOLD: thresh_ff <= pwdata[sixax_pkg::COUNT_BITS-1:0];
            sixax_pkg::CSR_TRANS_GAIN:     trans_gain_ff <= pwdata[sixax_pkg::GAIN_BITS-1:0];
            sixax_pkg::CSR_ROT_GAIN:       rot_gain_ff <= pwdata[sixax_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   sixax_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   sixax_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_event_type   (req_event_type),
      .req_event_code   (req_event_code),
      .req_event_value  (req_event_value),
      .idle_threshold   (thresh_ff),
      .trans_gain       (trans_gain_ff),
      .rot_gain         (rot_gain_ff),
      .cmd              (cmd),
      .status           (status),
      .rsp_coord_tx     (rsp_coord_tx),
      .rsp_coord_tz_neg (rsp_coord_tz_neg),
      .rsp_coord_ty_neg (rsp_coord_ty_neg),
      .rsp_coord_rx     (rsp_coord_rx),
      .rsp_coord_rz_neg (rsp_coord_rz_neg),
      .rsp_coord_ry_neg (rsp_coord_ry_neg),
      .rsp_button_one   (rsp_button_one),
      .rsp_button_two   (rsp_button_two)
   );

endmodule

// ===== dv/tb_six_axis_idle_hold_shaper_unit.sv =====
module tb_six_axis_idle_hold_shaper_unit;

   localparam int VAL_BITS = 12;
   localparam int AXIS_HI = (1 << (VAL_BITS - 1)) - 1;
   localparam int AXIS_LO = -(1 << (VAL_BITS - 1));
   localparam longint unsigned COORD_SAT = 64'd1100000;
   localparam logic ACT_EVENT = 1'b0;
   localparam logic ACT_FRAME = 1'b1;
   localparam logic [sixax_pkg::TYPE_BITS-1:0] EV_SYN = 5'd0;
   localparam logic [sixax_pkg::TYPE_BITS-1:0] EV_TYPE_TOP = 5'd31;
   localparam logic [sixax_pkg::CODE_BITS-1:0] CODE_TOP = 10'd1023;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 210;
   localparam int PHASES = 9;
   localparam logic [sixax_pkg::AXES-1:0] SLOT_NEG = 6'b110110;

   typedef struct packed {
      logic                             action;
      logic [sixax_pkg::TYPE_BITS-1:0]  ev_type;
      logic [sixax_pkg::CODE_BITS-1:0]  ev_code;
      logic [sixax_pkg::EVENT_BITS-1:0] ev_value;
   } hid_beat_type;

   typedef struct packed {
      logic [sixax_pkg::AXES-1:0][sixax_pkg::COORD_BITS-1:0] coord;
      logic [1:0][sixax_pkg::BUTTON_BITS-1:0]                button;
   } frame_out_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic [sixax_pkg::TYPE_BITS-1:0] req_event_type = '0;
   logic [sixax_pkg::CODE_BITS-1:0] req_event_code = '0;
   logic signed [sixax_pkg::EVENT_BITS-1:0] req_event_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [sixax_pkg::COORD_BITS-1:0] rsp_coord_tx, rsp_coord_tz_neg, rsp_coord_ty_neg;
   logic signed [sixax_pkg::COORD_BITS-1:0] rsp_coord_rx, rsp_coord_rz_neg, rsp_coord_ry_neg;
   logic [sixax_pkg::BUTTON_BITS-1:0] rsp_button_one, rsp_button_two;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   six_axis_idle_hold_shaper_unit #(.VALUE_BITS(VAL_BITS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_event_type(req_event_type), .req_event_code(req_event_code),
      .req_event_value(req_event_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_coord_tx(rsp_coord_tx), .rsp_coord_tz_neg(rsp_coord_tz_neg),
      .rsp_coord_ty_neg(rsp_coord_ty_neg), .rsp_coord_rx(rsp_coord_rx),
      .rsp_coord_rz_neg(rsp_coord_rz_neg), .rsp_coord_ry_neg(rsp_coord_ry_neg),
      .rsp_button_one(rsp_button_one), .rsp_button_two(rsp_button_two),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   hid_beat_type pending_beats [$];
   frame_out_type coord_queue [$];
   int queued_items = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   logic [31:0] cycle_count = '0;
   int send_gap = 0;
   int stall_left = 0;
   int rsp_taken = 0;

   int axis_val [sixax_pkg::AXES];
   logic [sixax_pkg::COUNT_BITS-1:0] idle_cnt [sixax_pkg::AXES];
   bit axis_hit [sixax_pkg::AXES];
   logic [sixax_pkg::BUTTON_BITS-1:0] btn_val [2];
   bit frame_dirty;
   logic [sixax_pkg::COUNT_BITS-1:0] idle_limit = sixax_pkg::IDLE_THRESHOLD_RESET;
   logic [sixax_pkg::GAIN_BITS-1:0] t_gain = sixax_pkg::TRANS_GAIN_RESET;
   logic [sixax_pkg::GAIN_BITS-1:0] r_gain = sixax_pkg::ROT_GAIN_RESET;
   int slot_src [sixax_pkg::AXES] = '{0, 2, 1, 3, 5, 4};
   string coord_names [sixax_pkg::AXES] = '{"coord_tx", "coord_tz_neg", "coord_ty_neg",
                                            "coord_rx", "coord_rz_neg", "coord_ry_neg"};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [sixax_pkg::COORD_BITS-1:0] shaped_coord(
      input int v, input logic [sixax_pkg::GAIN_BITS-1:0] gain);
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned q;
      logic [sixax_pkg::COORD_BITS-1:0] r;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      prod = mag * mag * longint'(gain);
      q = (v < 0) ? (prod + 64'd65535) >> 16 : prod >> 16;
      if (q > COORD_SAT) q = COORD_SAT;
      r = q[sixax_pkg::COORD_BITS-1:0];
      return (v < 0) ? -r : r;
   endfunction

   task automatic track_beat(input hid_beat_type b);
      int v;
      int sv;
      logic [sixax_pkg::BUTTON_BITS-1:0] k;
      frame_out_type o;
      v = int'($signed(b.ev_value));
      if (b.action == ACT_EVENT) begin
         frame_dirty = 1'b1;
         if (b.ev_type == sixax_pkg::EV_KEY) begin
            k = (v < 0) ? 2'd0 : (v > 3) ? 2'd3 : v[1:0];
            if (b.ev_code == sixax_pkg::BTN_CODE_ONE) btn_val[0] = k;
            else if (b.ev_code == sixax_pkg::BTN_CODE_TWO) btn_val[1] = k;
         end else if (b.ev_type == sixax_pkg::EV_REL || b.ev_type == sixax_pkg::EV_ABS) begin
            if (int'(b.ev_code) < sixax_pkg::AXES) begin
               axis_val[b.ev_code] = (v > AXIS_HI) ? AXIS_HI : (v < AXIS_LO) ? AXIS_LO : v;
               axis_hit[b.ev_code] = 1'b1;
            end
         end
      end else if (frame_dirty) begin
         for (int i = 0; i < sixax_pkg::AXES; i++) begin
            if (axis_hit[i]) idle_cnt[i] = '0;
            else if (idle_cnt[i] != sixax_pkg::IDLE_MAX) idle_cnt[i] = idle_cnt[i] + 1'b1;
            if (idle_cnt[i] >= idle_limit) axis_val[i] = 0;
            axis_hit[i] = 1'b0;
         end
         frame_dirty = 1'b0;
         for (int s = 0; s < sixax_pkg::AXES; s++) begin
            sv = SLOT_NEG[s] ? -axis_val[slot_src[s]] : axis_val[slot_src[s]];
            o.coord[s] = shaped_coord(sv, (s < 3) ? t_gain : r_gain);
         end
         o.button[0] = btn_val[0];
         o.button[1] = btn_val[1];
         coord_queue.push_back(o);
      end
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d got %0d", what, want, got);
   endtask

   task automatic check_result();
      frame_out_type got;
      frame_out_type want;
      got.coord[0] = rsp_coord_tx;
      got.coord[1] = rsp_coord_tz_neg;
      got.coord[2] = rsp_coord_ty_neg;
      got.coord[3] = rsp_coord_rx;
      got.coord[4] = rsp_coord_rz_neg;
      got.coord[5] = rsp_coord_ry_neg;
      got.button[0] = rsp_button_one;
      got.button[1] = rsp_button_two;
      if (coord_queue.size() == 0) begin
         report_mismatch("unexpected beat", 0, 1);
      end else begin
         want = coord_queue.pop_front();
         for (int i = 0; i < sixax_pkg::AXES; i++)
            if (got.coord[i] !== want.coord[i])
               report_mismatch(coord_names[i], int'($signed(want.coord[i])),
                               int'($signed(got.coord[i])));
         if (got.button[0] !== want.button[0])
            report_mismatch("button_one", int'(want.button[0]), int'(got.button[0]));
         if (got.button[1] !== want.button[1])
            report_mismatch("button_two", int'(want.button[1]), int'(got.button[1]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sixax_pkg::AXES; i++) begin
            axis_val[i] = 0;
            idle_cnt[i] = '0;
            axis_hit[i] = 1'b0;
         end
         btn_val[0] = '0;
         btn_val[1] = '0;
         frame_dirty = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall)
            track_beat({req_action, req_event_type, req_event_code, req_event_value});
      end
   end

   function automatic int pick_gap();
      int r;
      if (cycle_count[9:8] == 2'd0) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   always @(posedge clock) begin
      hid_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            req_action <= b.action;
            req_event_type <= b.ev_type;
            req_event_code <= b.ev_code;
            req_event_value <= b.ev_value;
            req_valid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // hold off for a long stretch twice so the shaper backs up into req_stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken++;
            if (rsp_taken == 40 || rsp_taken == 300) stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1'b1;
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_six_axis_idle_hold_shaper_unit NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_beat(input logic act, input logic [sixax_pkg::TYPE_BITS-1:0] t,
                            input logic [sixax_pkg::CODE_BITS-1:0] c, input int v);
      hid_beat_type b;
      b.action = act;
      b.ev_type = t;
      b.ev_code = c;
      b.ev_value = v[sixax_pkg::EVENT_BITS-1:0];
      pending_beats.push_back(b);
      queued_items++;
   endtask

   task automatic push_frame_end();
      push_beat(ACT_FRAME, sixax_pkg::TYPE_BITS'($urandom_range(0, 31)),
                sixax_pkg::CODE_BITS'($urandom_range(0, 1023)),
                int'($urandom_range(0, 65535)));
   endtask

   task automatic push_noise();
      push_beat(ACT_EVENT, sixax_pkg::TYPE_BITS'($urandom_range(0, 31)),
                sixax_pkg::CODE_BITS'($urandom_range(0, 1023)),
                int'($urandom_range(0, 65535)));
   endtask

   function automatic int rand_value();
      int r;
      int picks [8];
      picks = '{2047, -2048, 32767, -32768, 0, -1, 2048, -2049};
      r = int'($urandom_range(0, 99));
      if (r < 30) return int'($signed(16'($urandom_range(0, 65535))));
      if (r < 60) return int'($urandom_range(0, 4095)) - 2048;
      if (r < 75) return picks[$urandom_range(0, 7)];
      return int'($urandom_range(0, 128)) - 64;
   endfunction

   task automatic push_key();
      push_beat(ACT_EVENT, sixax_pkg::EV_KEY,
                $urandom_range(0, 1) ? sixax_pkg::BTN_CODE_ONE : sixax_pkg::BTN_CODE_TWO,
                ($urandom_range(0, 3) == 0) ? rand_value() :
                                              int'($urandom_range(0, 8)) - 3);
   endtask

   task automatic add_random_burst();
      int r;
      int n;
      r = int'($urandom_range(0, 99));
      if (r < 70) begin
         n = int'($urandom_range(1, 6));
         repeat (n) begin
            r = int'($urandom_range(0, 99));
            if (r < 75)
               push_beat(ACT_EVENT, $urandom_range(0, 1) ? sixax_pkg::EV_REL : sixax_pkg::EV_ABS,
                         sixax_pkg::CODE_BITS'($urandom_range(0, sixax_pkg::AXES - 1)),
                         rand_value());
            else if (r < 90) push_key();
            else push_noise();
         end
         push_frame_end();
      end else if (r < 85) begin
         if ($urandom_range(0, 1)) push_key();
         else push_noise();
         push_frame_end();
      end else if (r < 93) begin
         repeat ($urandom_range(1, 2)) push_frame_end();
      end else begin
         repeat ($urandom_range(1, 3)) push_noise();
      end
   endtask

   task automatic write_csr(input sixax_pkg::csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         sixax_pkg::CSR_IDLE_THRESHOLD: idle_limit = data[sixax_pkg::COUNT_BITS-1:0];
         sixax_pkg::CSR_TRANS_GAIN:     t_gain = data[sixax_pkg::GAIN_BITS-1:0];
         sixax_pkg::CSR_ROT_GAIN:       r_gain = data[sixax_pkg::GAIN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || coord_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_gain();
      return $urandom_range(0, 1) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 70000);
   endfunction

   initial begin : stimulus
      int start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      push_frame_end();
      push_beat(ACT_EVENT, sixax_pkg::EV_REL, 10'd0, 32767);
      push_beat(ACT_EVENT, sixax_pkg::EV_ABS, 10'd1, -32768);
      push_beat(ACT_EVENT, sixax_pkg::EV_REL, 10'd2, 0);
      push_beat(ACT_EVENT, sixax_pkg::EV_ABS, 10'd3, -1);
      push_beat(ACT_EVENT, sixax_pkg::EV_REL, 10'd4, 2047);
      push_beat(ACT_EVENT, sixax_pkg::EV_ABS, 10'd5, -2048);
      push_beat(ACT_EVENT, sixax_pkg::EV_KEY, sixax_pkg::BTN_CODE_ONE, -5);
      push_beat(ACT_EVENT, sixax_pkg::EV_KEY, sixax_pkg::BTN_CODE_TWO, 100);
      push_beat(ACT_EVENT, sixax_pkg::EV_KEY, 10'd0, 1);
      push_beat(ACT_EVENT, EV_SYN, CODE_TOP, -1);
      push_beat(ACT_EVENT, EV_TYPE_TOP, 10'd6, 5);
      push_beat(ACT_EVENT, sixax_pkg::EV_REL, CODE_TOP, 500);
      push_frame_end();
      push_beat(ACT_EVENT, sixax_pkg::EV_KEY, sixax_pkg::BTN_CODE_ONE, 2);
      push_frame_end();
      push_beat(ACT_EVENT, EV_SYN, 10'd0, 0);
      push_frame_end();
      push_frame_end();
      push_beat(ACT_EVENT, sixax_pkg::EV_KEY, sixax_pkg::BTN_CODE_TWO, 3);
      push_frame_end();
      push_beat(ACT_EVENT, sixax_pkg::EV_ABS, 10'd2, -2049);
      push_frame_end();
      push_beat(ACT_EVENT, sixax_pkg::EV_KEY, sixax_pkg::BTN_CODE_ONE, 1);
      push_frame_end();

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1: begin
                  write_csr(sixax_pkg::CSR_IDLE_THRESHOLD, 32'd15);
                  write_csr(sixax_pkg::CSR_TRANS_GAIN, 32'hFFFFF);
                  write_csr(sixax_pkg::CSR_ROT_GAIN, 32'hFFFFF);
               end
               2: begin
                  write_csr(sixax_pkg::CSR_IDLE_THRESHOLD, 32'd1);
                  write_csr(sixax_pkg::CSR_TRANS_GAIN, 32'd0);
                  write_csr(sixax_pkg::CSR_ROT_GAIN, 32'd0);
               end
               3, 4: begin
                  write_csr(sixax_pkg::CSR_IDLE_THRESHOLD,
                            (p == 3) ? 32'd0 : 32'(sixax_pkg::IDLE_THRESHOLD_RESET));
                  write_csr(sixax_pkg::CSR_TRANS_GAIN, 32'(sixax_pkg::TRANS_GAIN_RESET));
                  write_csr(sixax_pkg::CSR_ROT_GAIN, 32'(sixax_pkg::ROT_GAIN_RESET));
               end
               default: begin
                  write_csr(sixax_pkg::CSR_IDLE_THRESHOLD, $urandom_range(0, 15));
                  write_csr(sixax_pkg::CSR_TRANS_GAIN, rand_gain());
                  write_csr(sixax_pkg::CSR_ROT_GAIN, rand_gain());
               end
            endcase
         end
         start = queued_items;
         while (queued_items - start < PHASE_ITEMS) add_random_burst();
      end

      settle();
      if (mismatch_count == 0)
         $display("tb_six_axis_idle_hold_shaper_unit OK");
      else
         $display("tb_six_axis_idle_hold_shaper_unit NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sixax_pkg.sv
rtl/sixax_ctrl.sv
rtl/sixax_dpath.sv
rtl/six_axis_idle_hold_shaper_unit.sv
dv/tb_six_axis_idle_hold_shaper_unit.sv
